FILE: sv/rv32ie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32ie_pkg
// Shared types, encodings and helpers for the RV32I integer execute block.
// ----------------------------------------------------------------------------
package rv32ie_pkg;

  localparam int NumRegs = 32;
  localparam int RegAw = $clog2(NumRegs - 1);

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StUnknown = 2'd1,
    StIllegal = 2'd2,
    StOob     = 2'd3
  } status_e;

  localparam logic [4:0] OpcOpImm  = 5'h04;
  localparam logic [4:0] OpcAuipc  = 5'h05;
  localparam logic [4:0] OpcOp     = 5'h0C;
  localparam logic [4:0] OpcLui    = 5'h0D;
  localparam logic [4:0] OpcBranch = 5'h18;
  localparam logic [4:0] OpcJal    = 5'h1B;

  localparam logic [1:0] InsLowBits = 2'b11;

  localparam logic [2:0] F3Add  = 3'd0;
  localparam logic [2:0] F3Sll  = 3'd1;
  localparam logic [2:0] F3Slt  = 3'd2;
  localparam logic [2:0] F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor  = 3'd4;
  localparam logic [2:0] F3Srl  = 3'd5;
  localparam logic [2:0] F3Or   = 3'd6;
  localparam logic [2:0] F3And  = 3'd7;

  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;

  localparam logic [31:0] LimitReset = 32'h0002_0000;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] value;
    status_e     status;
    logic        halt;
  } ex_res_t;

  function automatic logic reg_ok(input logic [4:0] idx);
    return (idx != 5'd0) && (int'(idx) < NumRegs);
  endfunction

  function automatic logic [RegAw-1:0] rf_idx(input logic [4:0] idx);
    logic [4:0] tmp;
    tmp = idx - 5'd1;
    return tmp[RegAw-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/rv32ie_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32ie_alu
// Decode and execute of one instruction: result, next pc, write-back, status.
// ----------------------------------------------------------------------------
module rv32ie_alu (
  input  wire logic [31:0]         instr_i,
  input  wire logic [31:0]         rs1_i,
  input  wire logic [31:0]         rs2_i,
  input  wire logic [31:0]         pc_i,
  input  wire logic                halted_i,
  input  wire logic [31:0]         limit_i,
  output rv32ie_pkg::ex_res_t      res_o
);

  logic [4:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  sh;
  logic [31:0] imm_i;
  logic [31:0] imm_u;
  logic [31:0] off_b;
  logic [31:0] off_j;
  logic [31:0] pc_inc;
  logic        oob;
  logic        wr;
  logic        take;
  logic [31:0] res;
  logic [31:0] npc;
  rv32ie_pkg::status_e status;

  assign opc    = instr_i[6:2];
  assign rd     = instr_i[11:7];
  assign f3     = instr_i[14:12];
  assign f7     = instr_i[31:25];
  assign sh     = instr_i[24:20];
  assign imm_i  = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_u  = {instr_i[31:12], 12'h000};
  assign off_b  = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                   instr_i[11:8], 1'b0};
  assign off_j  = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                   instr_i[30:21], 1'b0};
  assign pc_inc = pc_i + 32'd4;
  assign oob    = (pc_i >= limit_i);

  always_comb begin
    npc    = pc_inc;
    status = rv32ie_pkg::StOk;
    wr     = 1'b0;
    res    = '0;
    take   = 1'b0;
    res_o.halt = 1'b0;
    if (halted_i) begin
      status = oob ? rv32ie_pkg::StOob : rv32ie_pkg::StIllegal;
      npc    = pc_i;
    end else if (oob) begin
      res_o.halt = 1'b1;
      status     = rv32ie_pkg::StOob;
      npc        = pc_i;
    end else if (instr_i[1:0] != rv32ie_pkg::InsLowBits) begin
      status = rv32ie_pkg::StUnknown;
    end else begin
      case (opc)
        rv32ie_pkg::OpcOpImm: begin
          wr = 1'b1;
          case (f3)
            rv32ie_pkg::F3Add:  res = rs1_i + imm_i;
            rv32ie_pkg::F3Sll: begin
              if (f7 == rv32ie_pkg::F7Base) res = rs1_i << sh;
              else wr = 1'b0;
            end
            rv32ie_pkg::F3Slt:  res = {31'd0, $signed(rs1_i) < $signed(imm_i)};
            rv32ie_pkg::F3Sltu: res = {31'd0, rs1_i < imm_i};
            rv32ie_pkg::F3Xor:  res = rs1_i ^ imm_i;
            rv32ie_pkg::F3Srl: begin
              if (f7 == rv32ie_pkg::F7Base) res = rs1_i >> sh;
              else if (f7 == rv32ie_pkg::F7Alt) res = $unsigned($signed(rs1_i) >>> sh);
              else wr = 1'b0;
            end
            rv32ie_pkg::F3Or:   res = rs1_i | imm_i;
            default:            res = rs1_i & imm_i;
          endcase
          if (!wr) status = rv32ie_pkg::StIllegal;
        end
        rv32ie_pkg::OpcOp: begin
          wr = 1'b1;
          if (f7 == rv32ie_pkg::F7Base) begin
            case (f3)
              rv32ie_pkg::F3Add:  res = rs1_i + rs2_i;
              rv32ie_pkg::F3Sll:  res = rs1_i << rs2_i[4:0];
              rv32ie_pkg::F3Slt:  res = {31'd0, $signed(rs1_i) < $signed(rs2_i)};
              rv32ie_pkg::F3Sltu: res = {31'd0, rs1_i < rs2_i};
              rv32ie_pkg::F3Xor:  res = rs1_i ^ rs2_i;
              rv32ie_pkg::F3Srl:  res = rs1_i >> rs2_i[4:0];
              rv32ie_pkg::F3Or:   res = rs1_i | rs2_i;
              default:            res = rs1_i & rs2_i;
            endcase
          end else if (f7 == rv32ie_pkg::F7Alt && f3 == rv32ie_pkg::F3Add) begin
            res = rs1_i - rs2_i;
          end else if (f7 == rv32ie_pkg::F7Alt && f3 == rv32ie_pkg::F3Srl) begin
            res = $unsigned($signed(rs1_i) >>> rs2_i[4:0]);
          end else begin
            wr     = 1'b0;
            status = rv32ie_pkg::StIllegal;
          end
        end
        rv32ie_pkg::OpcAuipc: begin
          wr  = 1'b1;
          res = pc_i + imm_u;
        end
        rv32ie_pkg::OpcLui: begin
          wr  = 1'b1;
          res = imm_u;
        end
        rv32ie_pkg::OpcJal: begin
          wr  = 1'b1;
          res = pc_inc;
          npc = pc_i + off_j;
        end
        rv32ie_pkg::OpcBranch: begin
          case (f3)
            rv32ie_pkg::F3Beq:  take = (rs1_i == rs2_i);
            rv32ie_pkg::F3Bne:  take = (rs1_i != rs2_i);
            rv32ie_pkg::F3Blt:  take = ($signed(rs1_i) < $signed(rs2_i));
            rv32ie_pkg::F3Bge:  take = !($signed(rs1_i) < $signed(rs2_i));
            rv32ie_pkg::F3Bltu: take = (rs1_i < rs2_i);
            rv32ie_pkg::F3Bgeu: take = (rs1_i >= rs2_i);
            default:            status = rv32ie_pkg::StIllegal;
          endcase
          if (take) npc = pc_i + off_b;
        end
        default: status = rv32ie_pkg::StUnknown;
      endcase
      if (status == rv32ie_pkg::StIllegal) begin
        res_o.halt = 1'b1;
        wr         = 1'b0;
        npc        = pc_i;
      end
    end
    res_o.next_pc = npc;
    res_o.status  = status;
    res_o.wr      = wr && rv32ie_pkg::reg_ok(rd);
    res_o.rd      = res_o.wr ? rd : 5'd0;
    res_o.value   = res_o.wr ? res : 32'd0;
  end

endmodule
`default_nettype wire

FILE: sv/rv32i_integer_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_integer_execute
// RV32I base integer execute with register file, pc and halt flag.
// ----------------------------------------------------------------------------
// usage
//   input channel: instr_i with in_valid_i / in_stall_o; a request is taken
//   at a clock edge with valid high and stall low. the word must be the one
//   fetched at the pc reported by the previous result (zero after reset).
//   output channel: next_pc_o, wb_valid_o, wb_reg_o, wb_value_o, status_o
//   with out_valid_o / out_stall_i, one result per request, in order.
//   config channel: cfg_valid_i / cfg_ready_o / cfg_wdata_i writes the
//   program limit; ready is always high. write only while idle.
//   a request goes from the operand read register, through execute, into
//   the result register. throughput: one request per cycle while the
//   receiver does not stall, set by the execute against the pc and register file.
//   register file reads are registered at acceptance with forwarding from
//   the instruction executing in that cycle.
//   reset: registers read as zero, pc is zero, not halted, limit 0x20000.
//   receiver stall: the result register holds and one more request can wait
//   in the operand stage; beyond that in_stall_o rises.
// ----------------------------------------------------------------------------
module rv32i_integer_execute (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output wire logic        in_stall_o,
  input  wire logic [31:0] instr_i,
  output wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  output wire logic [31:0] next_pc_o,
  output wire logic        wb_valid_o,
  output wire logic [4:0]  wb_reg_o,
  output wire logic [31:0] wb_value_o,
  output wire logic [1:0]  status_o,
  input  wire logic        cfg_valid_i,
  output wire logic        cfg_ready_o,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int Entries = rv32ie_pkg::NumRegs - 1;

  logic [31:0] rf_mem [Entries];
  logic [Entries-1:0] rf_valid_q;

  logic        ex_valid_q;
  logic [31:0] ex_instr_q;
  logic [31:0] ex_a_q;
  logic [31:0] ex_b_q;
  logic [31:0] pc_q;
  logic        halted_q;
  logic [31:0] limit_q;

  logic        out_valid_q;
  logic [31:0] out_pc_q;
  logic        out_wr_q;
  logic [4:0]  out_rd_q;
  logic [31:0] out_value_q;
  logic [1:0]  out_status_q;

  rv32ie_pkg::ex_res_t ex_res;
  logic accept;
  logic ex_fire;
  logic [4:0] rs1;
  logic [4:0] rs2;
  logic [rv32ie_pkg::RegAw-1:0] idx1;
  logic [rv32ie_pkg::RegAw-1:0] idx2;
  logic [rv32ie_pkg::RegAw-1:0] widx;
  logic fwd1;
  logic fwd2;
  logic live1;
  logic live2;

  assign ex_fire    = ex_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = ex_valid_q && !ex_fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign rs1   = instr_i[19:15];
  assign rs2   = instr_i[24:20];
  assign idx1  = rv32ie_pkg::rf_idx(rs1);
  assign idx2  = rv32ie_pkg::rf_idx(rs2);
  assign widx  = rv32ie_pkg::rf_idx(ex_res.rd);
  assign fwd1  = ex_fire && ex_res.wr && (ex_res.rd == rs1);
  assign fwd2  = ex_fire && ex_res.wr && (ex_res.rd == rs2);
  assign live1 = rv32ie_pkg::reg_ok(rs1) && rf_valid_q[idx1];
  assign live2 = rv32ie_pkg::reg_ok(rs2) && rf_valid_q[idx2];

  rv32ie_alu u_alu (
    .instr_i  (ex_instr_q),
    .rs1_i    (ex_a_q),
    .rs2_i    (ex_b_q),
    .pc_i     (pc_q),
    .halted_i (halted_q),
    .limit_i  (limit_q),
    .res_o    (ex_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      limit_q     <= rv32ie_pkg::LimitReset;
      rf_valid_q  <= '0;
    end else begin
      if (accept) ex_valid_q <= 1'b1;
      else if (ex_fire) ex_valid_q <= 1'b0;
      out_valid_q <= ex_fire || (out_valid_q && out_stall_i);
      if (cfg_valid_i) limit_q <= cfg_wdata_i;
      if (ex_fire) begin
        pc_q <= ex_res.next_pc;
        if (ex_res.halt) halted_q <= 1'b1;
        if (ex_res.wr) rf_valid_q[widx] <= 1'b1;
      end
    end
  end

  // register file and operand capture
  always_ff @(posedge clk_i) begin
    if (ex_fire && ex_res.wr) rf_mem[widx] <= ex_res.value;
    if (accept) begin
      ex_instr_q <= instr_i;
      ex_a_q     <= fwd1 ? ex_res.value : (live1 ? rf_mem[idx1] : 32'd0);
      ex_b_q     <= fwd2 ? ex_res.value : (live2 ? rf_mem[idx2] : 32'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_pc_q     <= ex_res.next_pc;
      out_wr_q     <= ex_res.wr;
      out_rd_q     <= ex_res.rd;
      out_value_q  <= ex_res.value;
      out_status_q <= ex_res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_pc_o   = out_pc_q;
  assign wb_valid_o  = out_wr_q;
  assign wb_reg_o    = out_rd_q;
  assign wb_value_o  = out_value_q;
  assign status_o    = out_status_q;
  assign cfg_ready_o = 1'b1;

  // halt is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halt flag cleared");

  // a halted block keeps its pc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && halted_q) |=> $stable(pc_q))
    else $error("pc moved while halted");

  // a reported halting status means the flag is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == rv32ie_pkg::StIllegal ||
                     out_status_q == rv32ie_pkg::StOob)) |-> halted_q)
    else $error("halt status without halt flag");

  // write-back never targets x0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_wr_q) |-> (out_rd_q != 5'd0))
    else $error("write-back to x0");

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rv32i_integer_execute. A driver feeds instruction
// words from a queue, with random gaps, and predicts each retirement from its
// own model of the register file, pc, halt flag and program limit. A monitor
// stalls the result channel at random and compares every retired result field
// by field. Phases run at the reset limit, a narrow limit and the full
// address space. The run ends by halting the block, through an illegal funct
// or the pc limit, chosen at random, and then checks the halted behaviour.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 400000;

  localparam logic [4:0] OpcLoad    = 5'h00;
  localparam logic [4:0] OpcMiscMem = 5'h03;
  localparam logic [4:0] OpcStore   = 5'h08;
  localparam logic [4:0] OpcJalr    = 5'h19;
  localparam logic [4:0] OpcSystem  = 5'h1C;

  typedef struct packed {
    logic [31:0][31:0] x;
    logic [31:0]       pc;
    logic              halted;
    logic [31:0]       limit;
  } hart_t;

  typedef struct packed {
    logic [31:0]         next_pc;
    logic                wb_valid;
    logic [4:0]          wb_reg;
    logic [31:0]         wb_value;
    rv32ie_pkg::status_e status;
  } retire_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] instr_i = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] next_pc_o;
  logic        wb_valid_o;
  logic [4:0]  wb_reg_o;
  logic [31:0] wb_value_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_wdata_i = 32'd0;

  logic [31:0] fetch_q[$];
  retire_t     retire_q[$];
  hart_t       live;
  hart_t       plan;
  retire_t     want;

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned limit_writes = 0;
  int unsigned cycle_count = 0;
  bit          halt_by_funct;

  int          send_gap = 0;
  int          send_run = 0;
  bit          send_quiet = 1'b0;
  bit          send_hold;
  int          recv_gap = 0;
  int          recv_run = 0;
  bit          recv_quiet = 1'b0;

  rv32i_integer_execute DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .instr_i     (instr_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .next_pc_o   (next_pc_o),
    .wb_valid_o  (wb_valid_o),
    .wb_reg_o    (wb_reg_o),
    .wb_value_o  (wb_value_o),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic hart_t fresh_hart();
    hart_t h;
    h = '0;
    h.limit = rv32ie_pkg::LimitReset;
    return h;
  endfunction

  function automatic logic [31:0] gpr(input hart_t h, input logic [4:0] idx);
    return (idx != 5'd0 && int'(idx) < rv32ie_pkg::NumRegs) ? h.x[idx] : 32'd0;
  endfunction

  // executes one word against the hart state and returns its retirement
  function automatic retire_t execute_word(inout hart_t h, input logic [31:0] w);
    retire_t             r;
    logic [31:0]         pc, npc, a, b, imm, res, off;
    logic [4:0]          rd, sh;
    logic [2:0]          f3;
    logic [6:0]          f7;
    logic                wr, take;
    rv32ie_pkg::status_e st;
    pc = h.pc;
    npc = pc + 32'd4;
    st = rv32ie_pkg::StOk;
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = gpr(h, w[19:15]);
    b = gpr(h, w[24:20]);
    imm = {{20{w[31]}}, w[31:20]};
    sh = w[24:20];
    res = 32'd0;
    wr = 1'b0;
    take = 1'b0;
    if (h.halted) begin
      st = (pc >= h.limit) ? rv32ie_pkg::StOob : rv32ie_pkg::StIllegal;
      npc = pc;
    end else if (pc >= h.limit) begin
      h.halted = 1'b1;
      st = rv32ie_pkg::StOob;
      npc = pc;
    end else if (w[1:0] != rv32ie_pkg::InsLowBits) begin
      st = rv32ie_pkg::StUnknown;
    end else begin
      case (w[6:2])
        rv32ie_pkg::OpcOpImm: begin
          wr = 1'b1;
          case (f3)
            rv32ie_pkg::F3Add:  res = a + imm;
            rv32ie_pkg::F3Sll: begin
              if (f7 == rv32ie_pkg::F7Base) res = a << sh;
              else wr = 1'b0;
            end
            rv32ie_pkg::F3Slt:  res = {31'd0, $signed(a) < $signed(imm)};
            rv32ie_pkg::F3Sltu: res = {31'd0, a < imm};
            rv32ie_pkg::F3Xor:  res = a ^ imm;
            rv32ie_pkg::F3Srl: begin
              if (f7 == rv32ie_pkg::F7Base) res = a >> sh;
              else if (f7 == rv32ie_pkg::F7Alt) res = $signed(a) >>> sh;
              else wr = 1'b0;
            end
            rv32ie_pkg::F3Or:   res = a | imm;
            default: res = a & imm;
          endcase
          if (!wr) st = rv32ie_pkg::StIllegal;
        end
        rv32ie_pkg::OpcOp: begin
          wr = 1'b1;
          if (f7 == rv32ie_pkg::F7Base) begin
            case (f3)
              rv32ie_pkg::F3Add:  res = a + b;
              rv32ie_pkg::F3Sll:  res = a << b[4:0];
              rv32ie_pkg::F3Slt:  res = {31'd0, $signed(a) < $signed(b)};
              rv32ie_pkg::F3Sltu: res = {31'd0, a < b};
              rv32ie_pkg::F3Xor:  res = a ^ b;
              rv32ie_pkg::F3Srl:  res = a >> b[4:0];
              rv32ie_pkg::F3Or:   res = a | b;
              default: res = a & b;
            endcase
          end else if (f7 == rv32ie_pkg::F7Alt && f3 == rv32ie_pkg::F3Add) begin
            res = a - b;
          end else if (f7 == rv32ie_pkg::F7Alt && f3 == rv32ie_pkg::F3Srl) begin
            res = $signed(a) >>> b[4:0];
          end else begin
            wr = 1'b0;
            st = rv32ie_pkg::StIllegal;
          end
        end
        rv32ie_pkg::OpcAuipc: begin
          wr = 1'b1;
          res = pc + {w[31:12], 12'd0};
        end
        rv32ie_pkg::OpcLui: begin
          wr = 1'b1;
          res = {w[31:12], 12'd0};
        end
        rv32ie_pkg::OpcJal: begin
          off = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
          wr = 1'b1;
          res = pc + 32'd4;
          npc = pc + off;
        end
        rv32ie_pkg::OpcBranch: begin
          off = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
          case (f3)
            rv32ie_pkg::F3Beq:  take = (a == b);
            rv32ie_pkg::F3Bne:  take = (a != b);
            rv32ie_pkg::F3Blt:  take = $signed(a) < $signed(b);
            rv32ie_pkg::F3Bge:  take = !($signed(a) < $signed(b));
            rv32ie_pkg::F3Bltu: take = (a < b);
            rv32ie_pkg::F3Bgeu: take = (a >= b);
            default: st = rv32ie_pkg::StIllegal;
          endcase
          if (take) npc = pc + off;
        end
        default: st = rv32ie_pkg::StUnknown;
      endcase
      if (st == rv32ie_pkg::StIllegal) begin
        h.halted = 1'b1;
        wr = 1'b0;
        npc = pc;
      end
    end
    if (wr && rd != 5'd0 && int'(rd) < rv32ie_pkg::NumRegs) h.x[rd] = res;
    else wr = 1'b0;
    h.pc = npc;
    r.next_pc = npc;
    r.wb_valid = wr;
    r.wb_reg = wr ? rd : 5'd0;
    r.wb_value = wr ? res : 32'd0;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [4:0] opc);
    return {imm, rs1, f3, rd, opc, rv32ie_pkg::InsLowBits};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return enc_i({f7, rs2}, rs1, f3, rd, rv32ie_pkg::OpcOp);
  endfunction

  function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                        input logic [4:0] opc);
    return {imm, rd, opc, rv32ie_pkg::InsLowBits};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] off, input logic [4:0] rd);
    return {off[20], off[10:1], off[11], off[19:12], rd, rv32ie_pkg::OpcJal,
            rv32ie_pkg::InsLowBits};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rv32ie_pkg::OpcBranch,
            rv32ie_pkg::InsLowBits};
  endfunction

  // a few low registers half the time, so results feed straight back
  function automatic logic [4:0] pick_reg();
    return $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic int pick_wait(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      quiet = ($urandom_range(0, 2) == 0);
      run_left = $urandom_range(4, 40);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [4:0]  rd, rs1, rs2, opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] imm;
    logic [20:0] joff;
    logic [12:0] boff;
    int          sel;
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    f3 = 3'($urandom_range(0, 7));
    imm = 12'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: imm = 12'h000;
        1: imm = 12'h7FF;
        2: imm = 12'h800;
        default: imm = 12'hFFF;
      endcase
    end
    joff = $urandom_range(0, 1) ? 21'($urandom_range(0, 255)) - 21'd128 : 21'($urandom);
    joff[0] = 1'b0;
    boff = $urandom_range(0, 1) ? 13'($urandom_range(0, 255)) - 13'd128 : 13'($urandom);
    boff[0] = 1'b0;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      if (f3 == rv32ie_pkg::F3Sll) imm[11:5] = rv32ie_pkg::F7Base;
      if (f3 == rv32ie_pkg::F3Srl)
        imm[11:5] = $urandom_range(0, 1) ? rv32ie_pkg::F7Alt : rv32ie_pkg::F7Base;
      w = enc_i(imm, rs1, f3, rd, rv32ie_pkg::OpcOpImm);
    end else if (sel < 50) begin
      f7 = ((f3 == rv32ie_pkg::F3Add || f3 == rv32ie_pkg::F3Srl) && $urandom_range(0, 1))
           ? rv32ie_pkg::F7Alt : rv32ie_pkg::F7Base;
      w = enc_r(f7, rs2, rs1, f3, rd);
    end else if (sel < 58) begin
      w = enc_u(20'($urandom), rd, rv32ie_pkg::OpcLui);
    end else if (sel < 63) begin
      w = enc_u(20'($urandom), rd, rv32ie_pkg::OpcAuipc);
    end else if (sel < 71) begin
      w = enc_j(joff, rd);
    end else if (sel < 86) begin
      case ($urandom_range(0, 5))
        0: f3 = rv32ie_pkg::F3Beq;
        1: f3 = rv32ie_pkg::F3Bne;
        2: f3 = rv32ie_pkg::F3Blt;
        3: f3 = rv32ie_pkg::F3Bge;
        4: f3 = rv32ie_pkg::F3Bltu;
        default: f3 = rv32ie_pkg::F3Bgeu;
      endcase
      w = enc_b(boff, rs2, rs1, f3);
    end else if (sel < 91) begin
      case ($urandom_range(0, 4))
        0: opc = OpcLoad;
        1: opc = OpcMiscMem;
        2: opc = OpcStore;
        3: opc = OpcJalr;
        default: opc = OpcSystem;
      endcase
      w = $urandom;
      w[6:0] = {opc, rv32ie_pkg::InsLowBits};
    end else if (sel < 95) begin
      w = $urandom;
      w[1:0] = 2'($urandom_range(0, 2));
    end else begin
      w = $urandom;
    end
    return w;
  endfunction

  function automatic logic [31:0] illegal_word();
    logic [6:0] f7;
    logic [2:0] f3;
    f7 = 7'($urandom_range(1, 127));
    if (f7 == rv32ie_pkg::F7Alt) f7 = 7'h21;
    f3 = 3'($urandom);
    case ($urandom_range(0, 3))
      0: return enc_i({f7, 5'($urandom)}, pick_reg(), rv32ie_pkg::F3Sll, pick_reg(),
                      rv32ie_pkg::OpcOpImm);
      1: return enc_i({f7, 5'($urandom)}, pick_reg(), rv32ie_pkg::F3Srl, pick_reg(),
                      rv32ie_pkg::OpcOpImm);
      2: begin
        if ($urandom_range(0, 1) && f3 != rv32ie_pkg::F3Add && f3 != rv32ie_pkg::F3Srl)
          f7 = rv32ie_pkg::F7Alt;
        return enc_r(f7, pick_reg(), pick_reg(), f3, pick_reg());
      end
      default: return enc_b(13'($urandom), pick_reg(), pick_reg(),
                            $urandom_range(0, 1) ? rv32ie_pkg::F3Slt : rv32ie_pkg::F3Sltu);
    endcase
  endfunction

  task automatic queue_word(input logic [31:0] w);
    void'(execute_word(plan, w));
    fetch_q.push_back(w);
  endtask

  // random words that keep the core running inside the program limit
  task automatic queue_random(input int n);
    logic [31:0] w;
    hart_t       trial;
    retire_t     r;
    int          tries;
    repeat (n) begin
      for (tries = 0; tries < 16; tries++) begin
        w = random_word();
        trial = plan;
        r = execute_word(trial, w);
        if (r.status != rv32ie_pkg::StIllegal && r.status != rv32ie_pkg::StOob &&
            r.next_pc < plan.limit) break;
      end
      if (tries == 16) w = enc_b(13'd0, 5'd0, 5'd0, rv32ie_pkg::F3Beq);
      queue_word(w);
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (fetch_q.size() != 0 || in_valid_i || retire_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [31:0] v);
    settle();
    @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    live.limit = v;
    plan.limit = v;
    limit_writes++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatch_count++;
    $display("tb: mismatch on %s at %0t: got %h, expected %h", what, $realtime, got,
             exp_val);
  endtask

  // request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      instr_i <= 32'd0;
    end else begin
      send_hold = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        retire_q.push_back(execute_word(live, instr_i));
        send_hold = 1'b0;
      end
      if (!send_hold) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (fetch_q.size() != 0) begin
          in_valid_i <= 1'b1;
          instr_i <= fetch_q.pop_front();
          send_gap = pick_wait(send_run, send_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (retire_q.size() == 0) begin
          report_mismatch("result with nothing pending", next_pc_o, 32'd0);
        end else begin
          want = retire_q.pop_front();
          if (next_pc_o !== want.next_pc) report_mismatch("next_pc", next_pc_o, want.next_pc);
          if (wb_valid_o !== want.wb_valid)
            report_mismatch("wb_valid", 32'(wb_valid_o), 32'(want.wb_valid));
          if (wb_reg_o !== want.wb_reg)
            report_mismatch("wb_reg", 32'(wb_reg_o), 32'(want.wb_reg));
          if (wb_value_o !== want.wb_value)
            report_mismatch("wb_value", wb_value_o, want.wb_value);
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        recv_gap = pick_wait(recv_run, recv_quiet);
      end else if (recv_gap != 0) begin
        recv_gap--;
      end
      out_stall_i <= (recv_gap != 0);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    live = fresh_hart();
    plan = fresh_hart();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, every operation, write to x0
    queue_word(enc_u(20'hFFFFF, 5'd1, rv32ie_pkg::OpcLui));
    queue_word(enc_i(12'hFFF, 5'd0, rv32ie_pkg::F3Add, 5'd2, rv32ie_pkg::OpcOpImm));
    queue_word(enc_i(12'h800, 5'd1, rv32ie_pkg::F3Slt, 5'd3, rv32ie_pkg::OpcOpImm));
    queue_word(enc_i(12'hFFF, 5'd1, rv32ie_pkg::F3Sltu, 5'd4, rv32ie_pkg::OpcOpImm));
    queue_word(enc_i(12'h7FF, 5'd2, rv32ie_pkg::F3Xor, 5'd5, rv32ie_pkg::OpcOpImm));
    queue_word(enc_i(12'h800, 5'd0, rv32ie_pkg::F3Or, 5'd6, rv32ie_pkg::OpcOpImm));
    queue_word(enc_i(12'h7FF, 5'd2, rv32ie_pkg::F3And, 5'd0, rv32ie_pkg::OpcOpImm));
    queue_word(enc_i({rv32ie_pkg::F7Base, 5'd31}, 5'd2, rv32ie_pkg::F3Sll, 5'd7,
                     rv32ie_pkg::OpcOpImm));
    queue_word(enc_i({rv32ie_pkg::F7Base, 5'd31}, 5'd1, rv32ie_pkg::F3Srl, 5'd8,
                     rv32ie_pkg::OpcOpImm));
    queue_word(enc_i({rv32ie_pkg::F7Alt, 5'd31}, 5'd1, rv32ie_pkg::F3Srl, 5'd9,
                     rv32ie_pkg::OpcOpImm));
    queue_word(enc_r(rv32ie_pkg::F7Base, 5'd7, 5'd2, rv32ie_pkg::F3Add, 5'd10));
    queue_word(enc_r(rv32ie_pkg::F7Alt, 5'd2, 5'd0, rv32ie_pkg::F3Add, 5'd11));
    queue_word(enc_r(rv32ie_pkg::F7Base, 5'd2, 5'd11, rv32ie_pkg::F3Sll, 5'd12));
    queue_word(enc_r(rv32ie_pkg::F7Base, 5'd11, 5'd1, rv32ie_pkg::F3Slt, 5'd13));
    queue_word(enc_r(rv32ie_pkg::F7Base, 5'd1, 5'd11, rv32ie_pkg::F3Sltu, 5'd14));
    queue_word(enc_r(rv32ie_pkg::F7Base, 5'd2, 5'd1, rv32ie_pkg::F3Xor, 5'd15));
    queue_word(enc_r(rv32ie_pkg::F7Base, 5'd2, 5'd12, rv32ie_pkg::F3Srl, 5'd16));
    queue_word(enc_r(rv32ie_pkg::F7Alt, 5'd11, 5'd12, rv32ie_pkg::F3Srl, 5'd17));
    queue_word(enc_r(rv32ie_pkg::F7Base, 5'd3, 5'd6, rv32ie_pkg::F3Or, 5'd18));
    queue_word(enc_r(rv32ie_pkg::F7Base, 5'd5, 5'd1, rv32ie_pkg::F3And, 5'd19));
    queue_word(enc_u(20'h80000, 5'd20, rv32ie_pkg::OpcAuipc));
    queue_word(enc_j(21'd12, 5'd21));
    queue_word(enc_b(13'd8, 5'd2, 5'd2, rv32ie_pkg::F3Beq));
    queue_word(enc_b(13'd8, 5'd1, 5'd1, rv32ie_pkg::F3Bne));
    queue_word(enc_b(13'd8, 5'd0, 5'd12, rv32ie_pkg::F3Blt));
    queue_word(enc_b(13'd8, 5'd11, 5'd12, rv32ie_pkg::F3Bge));
    queue_word(enc_b(13'd16, 5'd2, 5'd0, rv32ie_pkg::F3Bltu));
    queue_word(enc_b(13'd8, 5'd2, 5'd11, rv32ie_pkg::F3Bgeu));
    queue_word(32'h0000_0000);
    queue_word(32'hFFFF_FFFF);
    queue_random(400);

    // narrow window just above the current pc
    set_limit((plan.pc + 32'($urandom_range(32'h100, 32'h8000))) & ~32'h3);
    queue_random(300);

    // whole address space, with a wrap below zero and back
    set_limit(32'hFFFF_FFFF);
    if (plan.pc < 32'h0008_0000) begin
      queue_word(enc_j(21'(32'd0 - plan.pc - 32'd8), 5'd0));
      queue_word(enc_j(21'd16, 5'd5));
    end
    queue_random(380);

    halt_by_funct = 1'($urandom_range(0, 1));
    if (halt_by_funct) begin
      queue_word(illegal_word());
      repeat (6) queue_word(random_word());
      set_limit(32'd0);
      repeat (6) queue_word(random_word());
    end else begin
      set_limit($urandom_range(0, 1) ? plan.pc : plan.pc - (plan.pc >> $urandom_range(1, 8)));
      repeat (6) queue_word(random_word());
      set_limit(32'd0);
      repeat (6) queue_word(random_word());
    end
    set_limit(32'hFFFF_FFFF);
    repeat (6) queue_word(random_word());
    settle();
    repeat (8) @(posedge clk_i);

    $display("checked %0d retirements over %0d program limit writes, halted by %s",
             results_seen, limit_writes, halt_by_funct ? "an illegal funct" : "the pc limit");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: rv32i_integer_execute.f
sv/rv32ie_pkg.sv
sv/rv32ie_alu.sv
sv/rv32i_integer_execute.sv
bench/tb.sv
